// ===== sv/pll_pkg.sv =====
// Package for the positional list engine: payload structs, operation and
// status codes, cell control struct and fixed widths. No dependencies.

package pll_pkg;

  localparam int WORD_W = 32;
  // Cell index field; covers up to 64 cells.
  localparam int IDX_W  = 6;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DISPLAY   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SHOW = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic [5:0]               position;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] value_out;
    logic                     last;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         pick;
    logic [IDX_W-1:0]         tail;
    logic signed [WORD_W-1:0] word;
  } cell_ctrl_t;

endpackage

// ===== sv/positional_list_engine_unit.sv =====
// Ordered list of up to CAPACITY signed words kept in a chain of shifting
// cells. Inserts, deletes and refused operations load their result in the
// cycle that accepts them, so such items are accepted back to back while
// the output side keeps up. A display on a non-empty list is accepted
// first, then gives one element per cycle while the output side keeps up,
// as the chain rotates by one cell for each element. No new item is
// accepted until its last element has been loaded into the output register.
// Results sit in a single output register, so the next item is accepted
// only in a cycle where no result waits or the waiting one is transferred;
// a stalled output stalls the input. Uses pll_pkg and pll_cell.

module positional_list_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pll_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output pll_pkg::rsp_t   rsp
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = ((CntW > pll_pkg::IDX_W) ? CntW : pll_pkg::IDX_W) + 1;

  pll_pkg::state_t     state, state_next;
  logic [CntW-1:0]     count, count_next;
  logic [CntW-1:0]     remain, remain_next;
  pll_pkg::cell_ctrl_t ctrl;
  pll_pkg::rsp_t       rsp_next;
  logic                load_rsp;
  logic                take_removed;
  logic                out_free;
  logic                accept;
  logic                full, empty;
  logic [CmpW-1:0]     pos_x, cnt_x;
  logic signed [pll_pkg::WORD_W-1:0] removed_word;

  logic signed [pll_pkg::WORD_W-1:0] cell_word [CAPACITY];
  logic signed [pll_pkg::WORD_W-1:0] cell_rem  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pll_pkg::WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    pll_cell #(.INDEX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left    (left_w),
      .right   (right_w),
      .head    (cell_word[0]),
      .word    (cell_word[i]),
      .removed (cell_rem[i])
    );
  end

  // Only the picked cell drives a nonzero removed word.
  always_comb begin
    removed_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_word = removed_word | cell_rem[i];
    end
  end

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == pll_pkg::ST_IDLE) && out_free;
  assign accept    = req_valid && req_ready;
  assign full      = (count == CntW'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_x     = CmpW'(req.position);
  assign cnt_x     = CmpW'(count);

  always_comb begin
    state_next   = state;
    count_next   = count;
    remain_next  = remain;
    load_rsp     = 1'b0;
    take_removed = 1'b0;
    rsp_next     = '{status: pll_pkg::STAT_OK, value_out: '0, last: 1'b1};
    ctrl         = '{op: pll_pkg::CELL_HOLD, pick: '0,
                     tail: pll_pkg::IDX_W'(count - CntW'(1)), word: req.value};
    case (state)
      pll_pkg::ST_IDLE: begin
        if (accept) begin
          load_rsp = 1'b1;
          case (req.operation)
            pll_pkg::OP_INS_FRONT: begin
              if (full) begin
                rsp_next.status = pll_pkg::STAT_FULL;
              end else begin
                ctrl.op    = pll_pkg::CELL_INSERT;
                ctrl.pick  = '0;
                count_next = count + CntW'(1);
              end
            end
            pll_pkg::OP_INS_BACK: begin
              if (full) begin
                rsp_next.status = pll_pkg::STAT_FULL;
              end else begin
                ctrl.op    = pll_pkg::CELL_INSERT;
                ctrl.pick  = pll_pkg::IDX_W'(count);
                count_next = count + CntW'(1);
              end
            end
            pll_pkg::OP_INS_POS: begin
              if (req.position == '0 || pos_x > cnt_x + CmpW'(1)) begin
                rsp_next.status = pll_pkg::STAT_BADPOS;
              end else if (full) begin
                rsp_next.status = pll_pkg::STAT_FULL;
              end else begin
                ctrl.op    = pll_pkg::CELL_INSERT;
                ctrl.pick  = req.position - pll_pkg::IDX_W'(1);
                count_next = count + CntW'(1);
              end
            end
            pll_pkg::OP_DEL_FRONT: begin
              if (empty) begin
                rsp_next.status = pll_pkg::STAT_EMPTY;
              end else begin
                ctrl.op      = pll_pkg::CELL_DELETE;
                ctrl.pick    = '0;
                take_removed = 1'b1;
                count_next   = count - CntW'(1);
              end
            end
            pll_pkg::OP_DEL_BACK: begin
              if (empty) begin
                rsp_next.status = pll_pkg::STAT_EMPTY;
              end else begin
                ctrl.op      = pll_pkg::CELL_DELETE;
                ctrl.pick    = pll_pkg::IDX_W'(count - CntW'(1));
                take_removed = 1'b1;
                count_next   = count - CntW'(1);
              end
            end
            pll_pkg::OP_DEL_POS: begin
              if (req.position == '0 || pos_x > cnt_x) begin
                rsp_next.status = pll_pkg::STAT_BADPOS;
              end else begin
                ctrl.op      = pll_pkg::CELL_DELETE;
                ctrl.pick    = req.position - pll_pkg::IDX_W'(1);
                take_removed = 1'b1;
                count_next   = count - CntW'(1);
              end
            end
            pll_pkg::OP_DISPLAY: begin
              if (empty) begin
                rsp_next.status = pll_pkg::STAT_EMPTY;
              end else begin
                // results come from the rotation that follows
                load_rsp    = 1'b0;
                remain_next = count;
                state_next  = pll_pkg::ST_SHOW;
              end
            end
            default: rsp_next.status = pll_pkg::STAT_BADPOS;
          endcase
        end
      end
      pll_pkg::ST_SHOW: begin
        if (out_free) begin
          load_rsp           = 1'b1;
          ctrl.op            = pll_pkg::CELL_ROTATE;
          rsp_next.value_out = cell_word[0];
          rsp_next.last      = (remain == CntW'(1));
          remain_next        = remain - CntW'(1);
          if (remain == CntW'(1)) begin
            state_next = pll_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = pll_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pll_pkg::ST_IDLE;
      count     <= '0;
      remain    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Take the removed word straight from the chain on a delete.
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= '{status:    rsp_next.status,
               value_out: take_removed ? removed_word : rsp_next.value_out,
               last:      rsp_next.last};
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(CAPACITY))
    else $error("list count above capacity");

  a_show_blocks: assert property (@(posedge clk) disable iff (rst)
    state == pll_pkg::ST_SHOW |-> !req_ready && remain != '0)
    else $error("input taken or empty countdown during display");

  a_show_continues: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp.last |=> rsp_valid)
    else $error("display stream broke before last element");

  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !(req_valid && req_ready) |=> $stable(count))
    else $error("count changed without an accepted item");
`endif

endmodule

// ===== sv/pll_cell.sv =====
// One storage cell of the list chain: holds one word and takes its next
// value from itself, a neighbor, the head or the new word. Uses pll_pkg.

module pll_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  pll_pkg::cell_ctrl_t              ctrl,
  input  logic signed [pll_pkg::WORD_W-1:0] left,
  input  logic signed [pll_pkg::WORD_W-1:0] right,
  input  logic signed [pll_pkg::WORD_W-1:0] head,
  output logic signed [pll_pkg::WORD_W-1:0] word,
  output logic signed [pll_pkg::WORD_W-1:0] removed
);

  localparam logic [pll_pkg::IDX_W-1:0] MyIdx = pll_pkg::IDX_W'(INDEX);

  logic signed [pll_pkg::WORD_W-1:0] word_next;

  always_comb begin
    word_next = word;
    case (ctrl.op)
      pll_pkg::CELL_INSERT: begin
        if (MyIdx > ctrl.pick) begin
          word_next = left;
        end else if (MyIdx == ctrl.pick) begin
          word_next = ctrl.word;
        end
      end
      pll_pkg::CELL_DELETE: begin
        if (MyIdx >= ctrl.pick) begin
          word_next = right;
        end
      end
      pll_pkg::CELL_ROTATE: begin
        // tail takes the old head so the list returns after a full turn
        if (MyIdx == ctrl.tail) begin
          word_next = head;
        end else if (MyIdx < ctrl.tail) begin
          word_next = right;
        end
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign removed = (ctrl.op == pll_pkg::CELL_DELETE && MyIdx == ctrl.pick) ? word : '0;

endmodule

// ===== tb/pll_checker.sv =====
// Scoreboard for the positional list engine: keeps its own copy of the list,
// predicts the results of each request transfer and checks every response.
// Depends on pll_pkg for the payload structs and the operation/status codes.

module pll_checker #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  pll_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  pll_pkg::rsp_t rsp,
  output int            fail_count,
  output int            results_waiting,
  output int            stored_count
);

  logic signed [pll_pkg::WORD_W-1:0] list_words[$];
  pll_pkg::rsp_t                     pending_results[$];
  pll_pkg::rsp_t                     oldest;

  initial begin
    fail_count      = 0;
    results_waiting = 0;
    stored_count    = 0;
  end

  function automatic void queue_result(pll_pkg::status_t st,
                                       logic signed [pll_pkg::WORD_W-1:0] w,
                                       logic fin);
    pll_pkg::rsp_t r;
    r.status    = st;
    r.value_out = w;
    r.last      = fin;
    pending_results.push_back(r);
  endfunction

  // Run one request against the list copy and queue what it should produce.
  function automatic void apply_list_op(pll_pkg::req_t item);
    int                                n;
    int                                slot;
    logic signed [pll_pkg::WORD_W-1:0] w;
    n    = list_words.size();
    slot = int'(item.position) - 1;
    case (item.operation)
      pll_pkg::OP_INS_FRONT, pll_pkg::OP_INS_BACK: begin
        if (n >= CAPACITY) begin
          queue_result(pll_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          if (item.operation == pll_pkg::OP_INS_FRONT) list_words.push_front(item.value);
          else list_words.push_back(item.value);
          queue_result(pll_pkg::STAT_OK, '0, 1'b1);
        end
      end
      pll_pkg::OP_INS_POS: begin
        // position check wins over the full check
        if (item.position == 0 || int'(item.position) > n + 1) begin
          queue_result(pll_pkg::STAT_BADPOS, '0, 1'b1);
        end else if (n >= CAPACITY) begin
          queue_result(pll_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          list_words.insert(slot, item.value);
          queue_result(pll_pkg::STAT_OK, '0, 1'b1);
        end
      end
      pll_pkg::OP_DEL_FRONT, pll_pkg::OP_DEL_BACK: begin
        if (n == 0) begin
          queue_result(pll_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          if (item.operation == pll_pkg::OP_DEL_FRONT) w = list_words.pop_front();
          else w = list_words.pop_back();
          queue_result(pll_pkg::STAT_OK, w, 1'b1);
        end
      end
      pll_pkg::OP_DEL_POS: begin
        if (item.position == 0 || int'(item.position) > n) begin
          queue_result(pll_pkg::STAT_BADPOS, '0, 1'b1);
        end else begin
          w = list_words[slot];
          list_words.delete(slot);
          queue_result(pll_pkg::STAT_OK, w, 1'b1);
        end
      end
      pll_pkg::OP_DISPLAY: begin
        if (n == 0) begin
          queue_result(pll_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            queue_result(pll_pkg::STAT_OK, list_words[i], i == n - 1);
          end
        end
      end
      default: queue_result(pll_pkg::STAT_BADPOS, '0, 1'b1);
    endcase
  endfunction

  // Check the response first: it can never come from a request taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      list_words.delete();
      pending_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d value_out %0d last %0d",
                 rsp.status, rsp.value_out, rsp.last);
          fail_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (rsp.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, rsp.status);
            fail_count++;
          end
          if (rsp.value_out !== oldest.value_out) begin
            $error("value_out: expected %0d, got %0d", oldest.value_out, rsp.value_out);
            fail_count++;
          end
          if (rsp.last !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, rsp.last);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) apply_list_op(req);
    end
    results_waiting <= pending_results.size();
    stored_count    <= list_words.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the positional list engine testbench: clock, reset, request and
// response traffic, verdict. Depends on pll_pkg, positional_list_engine_unit
// and pll_checker.

module tb;

  localparam int         CAPACITY     = 32;
  localparam int         RANDOM_ITEMS = 310;
  localparam int         STALL_PCT    = 23;
  localparam int         HOLD_CYCLES  = 60;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [2:0] OP_UNUSED    = 3'd7;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  pll_pkg::req_t req;
  logic          rsp_valid;
  logic          rsp_ready;
  pll_pkg::rsp_t rsp;

  int   fail_count;
  int   results_waiting;
  int   stored_count;
  int   cycle_count = 0;
  logic steady      = 1'b0;
  logic hold_req    = 1'b0;
  bit   filling     = 1'b1;

  positional_list_engine_unit #(.CAPACITY(CAPACITY)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  pll_checker #(.CAPACITY(CAPACITY)) chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .rsp             (rsp),
    .fail_count      (fail_count),
    .results_waiting (results_waiting),
    .stored_count    (stored_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response side: random stalls, one long hold-off on request.
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= ($urandom_range(99) >= STALL_PCT);
      end
    end
  end

  task automatic send_op(input logic [2:0] op, input logic [5:0] pos,
                         input logic signed [pll_pkg::WORD_W-1:0] w);
    req_valid <= 1'b1;
    req       <= '{operation: op, position: pos, value: w};
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (results_waiting != 0);
  endtask

  // Mostly well-formed positions; the list drifts between empty and full.
  task automatic send_random();
    int                                len;
    int                                roll;
    int                                pick;
    bit                                grow;
    logic [2:0]                        op;
    logic [5:0]                        pos;
    logic signed [pll_pkg::WORD_W-1:0] w;
    len = stored_count;
    if (len >= CAPACITY) filling = 1'b0;
    else if (len == 0) filling = 1'b1;
    else if ($urandom_range(99) < 4) filling = !filling;
    roll = $urandom_range(99);
    pick = $urandom_range(3);
    w    = $urandom();
    if ($urandom_range(9) == 0) w = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    pos  = 6'($urandom_range(63));
    op   = pll_pkg::OP_DISPLAY;
    if (roll >= 10 && roll < 13) begin
      op = OP_UNUSED;
    end else if (roll >= 13) begin
      grow = filling ? (roll < 87) : (roll >= 87);
      if (grow) begin
        op = (pick == 0) ? pll_pkg::OP_INS_FRONT :
             (pick == 1) ? pll_pkg::OP_INS_BACK : pll_pkg::OP_INS_POS;
        if ($urandom_range(99) < 85) pos = 6'($urandom_range(len + 1, 1));
      end else begin
        op = (pick == 0) ? pll_pkg::OP_DEL_FRONT :
             (pick == 1) ? pll_pkg::OP_DEL_BACK : pll_pkg::OP_DEL_POS;
        if (len > 0 && $urandom_range(99) < 85) pos = 6'($urandom_range(len, 1));
      end
    end
    send_op(op, pos, w);
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Refusals on an empty list, then a short list built from the extremes.
    send_op(pll_pkg::OP_DISPLAY,   6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_FRONT, 6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_BACK,  6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_POS,   6'd1,  32'sd0);
    send_op(pll_pkg::OP_INS_POS,   6'd0,  32'sd5);
    send_op(pll_pkg::OP_INS_POS,   6'd2,  32'sd5);
    send_op(pll_pkg::OP_INS_FRONT, 6'd0,  32'sh7fffffff);
    send_op(pll_pkg::OP_INS_BACK,  6'd63, 32'sh80000000);
    send_op(pll_pkg::OP_INS_POS,   6'd2,  -32'sd1);
    send_op(pll_pkg::OP_INS_POS,   6'd4,  32'sd0);
    send_op(pll_pkg::OP_INS_POS,   6'd63, 32'sd7);
    send_op(pll_pkg::OP_DEL_POS,   6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_POS,   6'd5,  32'sd0);
    send_op(pll_pkg::OP_DISPLAY,   6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_POS,   6'd2,  32'sd0);
    send_op(pll_pkg::OP_DEL_FRONT, 6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_BACK,  6'd0,  32'sd0);
    send_op(OP_UNUSED,             6'd63, -32'sd1);
    send_op(pll_pkg::OP_DISPLAY,   6'd0,  32'sd0);
    send_op(pll_pkg::OP_DEL_POS,   6'd1,  32'sd0);
    send_op(pll_pkg::OP_DISPLAY,   6'd0,  32'sd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady <= (i >= 200 && i < 260);
      if (i == 40) hold_req <= 1'b1;
      if (i == 120) begin
        wait_drained();
      end else if (!(i >= 200 && i < 260) && $urandom_range(99) < STALL_PCT) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge clk);
      end
      send_random();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
